// ===== sv/dq_pkg.sv =====
// Package for the double-ended queue: sizes, operation and status codes, command type.
package dq_pkg;

   // Number of words the queue can hold (2 to 4096)
   localparam int CAPACITY = 16;

   // Slot index width and fill count width (count must reach CAPACITY)
   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   localparam int WORD_W = 32;
   localparam int OP_W   = 3;
   localparam int STAT_W = 2;

   // Operation codes
   localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
   localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
   localparam logic [OP_W-1:0] OP_PEEK_FRONT = 3'd4;
   localparam logic [OP_W-1:0] OP_PEEK_BACK  = 3'd5;

   // Status codes
   localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd2;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic capture;   // latch the request word and start the storage read
      logic commit;    // update pointers, write storage, load the response word
   } dq_cmd_type;

endpackage

// ===== sv/double_ended_queue_core.sv =====
// Top level of the double-ended queue: controller plus datapath.
// A bounded deque of signed 32-bit words held in a ring buffer of CAPACITY
// entries (dq_pkg). Each request word carries an opcode (push front/back, pop
// front/back, peek front/back) and a push value, and gives exactly one
// response word with the value read, a status (ok, empty, full) and a flag
// that the queue is now empty. A request is handled in a capture step, which
// takes it and starts the registered storage read, then a commit step, which
// updates the ring pointers and loads the response register once the output
// register is free; no new request is taken before the commit. A response
// waiting in the output register does not stop the next request from being
// taken. No clearing is needed after reset; the queue is empty at once.
module double_ended_queue_core
   import dq_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic        [OP_W-1:0]   req_opcode,
   input  logic signed [WORD_W-1:0] req_push_value,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [WORD_W-1:0] rsp_read_value,
   output logic        [STAT_W-1:0] rsp_status,
   output logic                     rsp_now_empty
);

   dq_cmd_type cmd;

   dq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   dq_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_opcode     (req_opcode),
      .req_push_value (req_push_value),
      .rsp_read_value (rsp_read_value),
      .rsp_status     (rsp_status),
      .rsp_now_empty  (rsp_now_empty)
   );

endmodule

// ===== sv/dq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module dq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/dq_ctrl.sv =====
// Controller for the double-ended queue: request/response handshakes and sequencing.
module dq_ctrl
   import dq_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output dq_cmd_type cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   // Output register can take a new word when empty or being drained
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Next state and commands
   always_comb begin
      state_in    = state_ff;
      cmd.capture = 1'b0;
      cmd.commit  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Response valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== sv/dq_datapath.sv =====
// Datapath for the double-ended queue: ring pointers, word storage and response word.
module dq_datapath
   import dq_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  dq_cmd_type               cmd,
   input  logic        [OP_W-1:0]   req_opcode,
   input  logic signed [WORD_W-1:0] req_push_value,
   output logic signed [WORD_W-1:0] rsp_read_value,
   output logic        [STAT_W-1:0] rsp_status,
   output logic                     rsp_now_empty
);

   localparam int SUM_W = CNT_W + 1;

   logic [IDX_W-1:0]  head_ff, head_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [OP_W-1:0]   op_ff;
   logic [WORD_W-1:0] value_ff;

   logic signed [WORD_W-1:0] read_value_ff, read_value_in;
   logic [STAT_W-1:0]        status_ff, status_in;
   logic                     now_empty_ff;

   logic [IDX_W-1:0]  head_prev, head_next, tail_slot, back_slot, rd_addr, wr_addr;
   logic [SUM_W-1:0]  tail_sum, back_sum;
   logic              full, empty, wr_en;
   logic [WORD_W-1:0] rd_data;

   // Ring slot arithmetic; for a non-empty queue sums stay below twice the capacity
   assign tail_sum  = SUM_W'(head_ff) + SUM_W'(count_ff) - SUM_W'(1);
   assign back_sum  = SUM_W'(head_ff) + SUM_W'(count_ff);
   assign tail_slot = (tail_sum >= SUM_W'(CAPACITY)) ?
                      IDX_W'(tail_sum - SUM_W'(CAPACITY)) : IDX_W'(tail_sum);
   assign back_slot = (back_sum >= SUM_W'(CAPACITY)) ?
                      IDX_W'(back_sum - SUM_W'(CAPACITY)) : IDX_W'(back_sum);
   assign head_prev = (head_ff == '0) ? IDX_W'(CAPACITY - 1) : head_ff - IDX_W'(1);
   assign head_next = (head_ff == IDX_W'(CAPACITY - 1)) ? '0 : head_ff + IDX_W'(1);

   assign full  = (count_ff == CNT_W'(CAPACITY));
   assign empty = (count_ff == '0);

   // Read the front or back word as the request is taken
   assign rd_addr = (req_opcode == OP_POP_BACK || req_opcode == OP_PEEK_BACK) ?
                    tail_slot : head_ff;

   dq_ram #(
      .WIDTH (WORD_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (value_ff),
      .rd_en   (cmd.capture),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Operation at commit: pointer update, storage write, response word
   always_comb begin
      head_in       = head_ff;
      count_in      = count_ff;
      read_value_in = '0;
      status_in     = STATUS_OK;
      wr_en         = 1'b0;
      wr_addr       = back_slot;
      unique case (op_ff)
         OP_PUSH_FRONT, OP_PUSH_BACK: begin
            if (full) begin
               status_in = STATUS_FULL;
            end else begin
               wr_en    = cmd.commit;
               count_in = count_ff + CNT_W'(1);
               if (op_ff == OP_PUSH_FRONT) begin
                  wr_addr = head_prev;
                  head_in = head_prev;
               end
            end
         end
         OP_POP_FRONT, OP_PEEK_FRONT, OP_POP_BACK, OP_PEEK_BACK: begin
            if (empty) begin
               status_in = STATUS_EMPTY;
            end else begin
               read_value_in = $signed(rd_data);
               if (op_ff == OP_POP_FRONT) begin
                  head_in  = head_next;
                  count_in = count_ff - CNT_W'(1);
               end else if (op_ff == OP_POP_BACK) begin
                  count_in = count_ff - CNT_W'(1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Queue pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else if (cmd.commit) begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   // Request capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= req_opcode;
         value_ff <= req_push_value;
      end
   end

   // Response word
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         read_value_ff <= read_value_in;
         status_ff     <= status_in;
         now_empty_ff  <= (count_in == '0);
      end
   end

   assign rsp_read_value = read_value_ff;
   assign rsp_status     = status_ff;
   assign rsp_now_empty  = now_empty_ff;

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the double-ended queue: directed, capacity, stall and random traffic.
module tb_top
   import dq_pkg::*;
();

   // Opcodes with no operation behind them
   localparam logic [OP_W-1:0] OP_NOP_LO = 3'd6;
   localparam logic [OP_W-1:0] OP_NOP_HI = 3'd7;

   localparam logic signed [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};
   localparam logic signed [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};

   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 20;
   localparam int MAX_GAP       = 40;
   localparam int REPORT_LIMIT  = 10;

   typedef struct packed {
      logic signed [WORD_W-1:0] read_value;
      logic [STAT_W-1:0]        status;
      logic                     now_empty;
   } deque_result_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic        [OP_W-1:0]   req_opcode = '0;
   logic signed [WORD_W-1:0] req_push_value = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic signed [WORD_W-1:0] rsp_read_value;
   logic        [STAT_W-1:0] rsp_status;
   logic                     rsp_now_empty;

   // Shadow copy of the deque
   logic signed [WORD_W-1:0] shadow_slots [CAPACITY];
   int shadow_head  = 0;
   int shadow_count = 0;

   deque_result_type expected_words[$];
   deque_result_type want_word, got_word;
   int mismatch_count = 0;
   int cycle_count    = 0;
   int send_idle_pct  = 0;
   int recv_idle_pct  = 0;
   int recv_hold_cycles = 0;

   double_ended_queue_core DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_opcode     (req_opcode),
      .req_push_value (req_push_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_read_value (rsp_read_value),
      .rsp_status     (rsp_status),
      .rsp_now_empty  (rsp_now_empty)
   );

   always #5 clock = ~clock;

   // Run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Apply one operation to the shadow deque and return the word it should answer with
   function automatic deque_result_type predict_deque_op(logic [OP_W-1:0] op,
                                                         logic signed [WORD_W-1:0] word);
      deque_result_type res;
      int tail;
      res = '{read_value: '0, status: STATUS_OK, now_empty: 1'b0};
      tail = (shadow_head + shadow_count + CAPACITY - 1) % CAPACITY;
      case (op)
         OP_PUSH_FRONT, OP_PUSH_BACK: begin
            if (shadow_count >= CAPACITY) begin
               res.status = STATUS_FULL;
            end else if (op == OP_PUSH_FRONT) begin
               shadow_head = (shadow_head + CAPACITY - 1) % CAPACITY;
               shadow_slots[IDX_W'(shadow_head)] = word;
               shadow_count++;
            end else begin
               shadow_slots[IDX_W'((shadow_head + shadow_count) % CAPACITY)] = word;
               shadow_count++;
            end
         end
         OP_POP_FRONT, OP_POP_BACK, OP_PEEK_FRONT, OP_PEEK_BACK: begin
            if (shadow_count == 0) begin
               res.status = STATUS_EMPTY;
            end else if (op == OP_POP_FRONT || op == OP_PEEK_FRONT) begin
               res.read_value = shadow_slots[IDX_W'(shadow_head)];
               if (op == OP_POP_FRONT) begin
                  shadow_head = (shadow_head + 1) % CAPACITY;
                  shadow_count--;
               end
            end else begin
               res.read_value = shadow_slots[IDX_W'(tail)];
               if (op == OP_POP_BACK) shadow_count--;
            end
         end
         default: ;
      endcase
      res.now_empty = (shadow_count == 0);
      return res;
   endfunction

   function automatic void note_mismatch(string what, logic [WORD_W-1:0] want,
                                         logic [WORD_W-1:0] got);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("MISMATCH %s at cycle %0d: expected %h, got %h", what, cycle_count, want, got);
   endfunction

   // Response checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         got_word = '{read_value: rsp_read_value, status: rsp_status,
                      now_empty: rsp_now_empty};
         if (expected_words.size() == 0) begin
            note_mismatch("unexpected word", '0, got_word.read_value);
         end else begin
            want_word = expected_words.pop_front();
            if (got_word.read_value !== want_word.read_value)
               note_mismatch("read_value", want_word.read_value, got_word.read_value);
            if (got_word.status !== want_word.status)
               note_mismatch("status", WORD_W'(want_word.status), WORD_W'(got_word.status));
            if (got_word.now_empty !== want_word.now_empty)
               note_mismatch("now_empty", WORD_W'(want_word.now_empty),
                             WORD_W'(got_word.now_empty));
         end
      end
   end

   // Response side: long hold-off when asked, random stalls otherwise
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (recv_hold_cycles > 0) begin
         rsp_ready <= 1'b0;
         recv_hold_cycles--;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Offer one request word; entered and left at a falling edge
   task automatic offer_word(input logic [OP_W-1:0] op, input logic signed [WORD_W-1:0] word);
      int gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid  <= 1'b0;
         req_opcode <= OP_W'($urandom);
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_opcode     <= op;
      req_push_value <= word;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_words.push_back(predict_deque_op(op, word));
      @(negedge clock);
   endtask

   task automatic stop_offering();
      req_valid <= 1'b0;
      @(negedge clock);
   endtask

   // Sender pauses until every outstanding response is back
   task automatic wait_drained();
      stop_offering();
      while (expected_words.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function automatic logic signed [WORD_W-1:0] pick_word();
      case ($urandom_range(19))
         0: return WORD_MIN;
         1: return WORD_MAX;
         2: return '0;
         3: return '1;
         default: return $urandom;
      endcase
   endfunction

   // Empty-queue errors, unused opcodes, extreme words at both ends
   task automatic test_directed();
      offer_word(OP_PEEK_FRONT, $urandom);
      offer_word(OP_PEEK_BACK, $urandom);
      offer_word(OP_POP_FRONT, $urandom);
      offer_word(OP_POP_BACK, $urandom);
      offer_word(OP_NOP_LO, $urandom);
      offer_word(OP_NOP_HI, $urandom);
      offer_word(OP_PUSH_BACK, WORD_MAX);
      offer_word(OP_PUSH_FRONT, WORD_MIN);
      offer_word(OP_PEEK_FRONT, $urandom);
      offer_word(OP_PEEK_BACK, $urandom);
      offer_word(OP_NOP_HI, $urandom);
      offer_word(OP_POP_BACK, $urandom);
      offer_word(OP_POP_FRONT, $urandom);
      offer_word(OP_PUSH_FRONT, '1);
      offer_word(OP_PUSH_BACK, '0);
      offer_word(OP_POP_FRONT, $urandom);
      offer_word(OP_POP_FRONT, $urandom);
      offer_word(OP_PUSH_BACK, 32'sh5555_5555);
      offer_word(OP_PUSH_FRONT, 32'shAAAA_AAAA);
      offer_word(OP_POP_BACK, $urandom);
      offer_word(OP_POP_BACK, $urandom);
      offer_word(OP_POP_BACK, $urandom);
      wait_drained();
   endtask

   // Fill to capacity, push into a full queue at both ends, then drain past empty
   task automatic test_capacity_limits();
      for (int i = 0; i < CAPACITY; i++)
         offer_word($urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK, pick_word());
      offer_word(OP_PUSH_FRONT, pick_word());
      offer_word(OP_PUSH_BACK, pick_word());
      offer_word(OP_PEEK_FRONT, $urandom);
      offer_word(OP_PEEK_BACK, $urandom);
      for (int i = 0; i < CAPACITY; i++)
         offer_word($urandom_range(1) ? OP_POP_FRONT : OP_POP_BACK, $urandom);
      offer_word(OP_POP_FRONT, $urandom);
      offer_word(OP_PEEK_BACK, $urandom);
      wait_drained();
   endtask

   // Responses held off for a long stretch while requests keep coming
   task automatic test_response_stall();
      int saved_send, saved_recv;
      saved_send = send_idle_pct;
      saved_recv = recv_idle_pct;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      @(posedge clock);
      recv_hold_cycles = 100;
      @(negedge clock);
      for (int i = 0; i < 20; i++)
         offer_word(i < 12 ? OP_PUSH_BACK : OP_POP_FRONT, pick_word());
      wait_drained();
      send_idle_pct = saved_send;
      recv_idle_pct = saved_recv;
   endtask

   // Mostly fill/drain runs so the queue swings between empty and full, plus noise
   task automatic test_random_traffic(input int n_words, input int send_pct, input int recv_pct);
      bit filling;
      int pick;
      logic [OP_W-1:0] op;
      filling = 1'b1;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      for (int i = 0; i < n_words; i++) begin
         if (shadow_count >= CAPACITY && $urandom_range(3) == 0) filling = 1'b0;
         if (shadow_count == 0 && $urandom_range(3) == 0) filling = 1'b1;
         if ($urandom_range(49) == 0) filling = ~filling;
         pick = $urandom_range(99);
         if (pick < 4)
            op = $urandom_range(1) ? OP_NOP_LO : OP_NOP_HI;
         else if (pick < 14)
            op = $urandom_range(1) ? OP_PEEK_FRONT : OP_PEEK_BACK;
         else if ($urandom_range(99) < (filling ? 75 : 25))
            op = $urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
         else
            op = $urandom_range(1) ? OP_POP_FRONT : OP_POP_BACK;
         offer_word(op, pick_word());
      end
      wait_drained();
   endtask

   initial begin
      for (int i = 0; i < CAPACITY; i++) shadow_slots[IDX_W'(i)] = '0;
      send_idle_pct = 15;
      recv_idle_pct = 77;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed();
      test_capacity_limits();
      test_random_traffic(300, 15, 77);
      test_random_traffic(300, 77, 15);
      test_response_stall();
      test_random_traffic(300, 0, 0);

      if (mismatch_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ===== sim.f =====
sv/dq_pkg.sv
sv/dq_ram.sv
sv/dq_ctrl.sv
sv/dq_datapath.sv
sv/double_ended_queue_core.sv
dv/tb_top.sv
